@@ hdl/ffsa_pkg.sv @@
// Shared constants, codes and controller/datapath signal groups for the slot allocator.
package ffsa_pkg;

	// Slot map geometry
	localparam int SLOT_COUNT = 1024;
	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

	// Field widths of the request and response
	localparam int SIZE_W     = 11;
	localparam int START_W    = 10;
	localparam int GRANT_W    = 10;
	localparam int STATUS_W   = 2;

	// Width that holds slot counts, request sizes and their sums without overflow
	localparam int CMP_W      = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK            = 2'd0,
		ST_NO_SPACE      = 2'd1,
		ST_OUT_OF_BOUNDS = 2'd2
	} status_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic    load_req;   // capture the request on an input transfer
		logic    clear_step; // write one free mark during the post-reset sweep
		logic    scan_start; // restart the first-fit scan at slot 0
		logic    scan_step;  // issue one map read and check the previous one
		logic    free_start; // aim the write pointer at the range to free
		logic    fill_step;  // write one slot of the run and advance
		logic    load_out;   // load the response register
		status_t rsp_status; // status code for the response
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		mode_t mode;
		logic  size_zero;
		logic  size_big;
		logic  free_oob;
		logic  found;
		logic  scan_done;
		logic  fill_last;
		logic  clear_last;
		logic  out_free;
	} stat_t;

endpackage

@@ hdl/ffsa_req_if.sv @@
// Request channel: valid/ready handshake carrying one allocate or free request.
interface ffsa_req_if;
	logic                         valid;
	logic                         ready;
	logic                         mode;
	logic [ffsa_pkg::SIZE_W-1:0]  request_size;
	logic [ffsa_pkg::START_W-1:0] start_slot;

	modport source (output valid, output mode, output request_size, output start_slot,
		input ready);
	modport sink (input valid, input mode, input request_size, input start_slot,
		output ready);
endinterface

@@ hdl/ffsa_rsp_if.sv @@
// Response channel: valid/ready handshake carrying one status and granted slot.
interface ffsa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ffsa_pkg::STATUS_W-1:0] status;
	logic [ffsa_pkg::GRANT_W-1:0]  granted_slot;

	modport source (output valid, output status, output granted_slot, input ready);
	modport sink (input valid, input status, input granted_slot, output ready);
endinterface

@@ hdl/ffsa_ctrl.sv @@
// Controller state machine: sequences clearing, checks, map scan, run fill and response.
module ffsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ffsa_pkg::stat_t stat,
	output ffsa_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_FILL,
		S_FINISH
	} state_t;

	state_t            state_q;
	ffsa_pkg::status_t rcode_q;

	assign req_ready = (state_q == S_IDLE);

	// Decode commands from the current state
	always_comb begin
		cmd            = '0;
		cmd.rsp_status = rcode_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			S_IDLE: begin
				cmd.load_req = req_valid;
			end
			S_CHECK: begin
				if (stat.mode == ffsa_pkg::MODE_ALLOC) begin
					cmd.scan_start = !(stat.size_zero || stat.size_big);
				end else begin
					cmd.free_start = !stat.free_oob && !stat.size_zero;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
			end
			S_FINISH: begin
				cmd.load_out = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Hold state and the pending response code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			rcode_q <= ffsa_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (stat.mode == ffsa_pkg::MODE_ALLOC) begin
						if (stat.size_zero || stat.size_big) begin
							rcode_q <= ffsa_pkg::ST_NO_SPACE;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_SCAN;
						end
					end else begin
						if (stat.free_oob) begin
							rcode_q <= ffsa_pkg::ST_OUT_OF_BOUNDS;
							state_q <= S_FINISH;
						end else if (stat.size_zero) begin
							rcode_q <= ffsa_pkg::ST_OK;
							state_q <= S_FINISH;
						end else begin
							rcode_q <= ffsa_pkg::ST_OK;
							state_q <= S_FILL;
						end
					end
				end
				S_SCAN: begin
					if (stat.found) begin
						rcode_q <= ffsa_pkg::ST_OK;
						state_q <= S_FILL;
					end else if (stat.scan_done) begin
						rcode_q <= ffsa_pkg::ST_NO_SPACE;
						state_q <= S_FINISH;
					end
				end
				S_FILL: begin
					if (stat.fill_last) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

endmodule

@@ hdl/ffsa_dpath.sv @@
// Datapath: slot map memory, scan and fill counters, request and response registers.
module ffsa_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_mode,
	input  logic [ffsa_pkg::SIZE_W-1:0]  req_size,
	input  logic [ffsa_pkg::START_W-1:0] req_start,
	input  ffsa_pkg::cmd_t               cmd,
	output ffsa_pkg::stat_t              stat,
	ffsa_rsp_if.source                   rsp
);

	// Slot map: one used bit per slot, one write and one registered read per cycle
	logic                          map_mem [ffsa_pkg::SLOT_COUNT];
	logic                          map_we;
	logic [ffsa_pkg::IDX_W-1:0]    map_waddr;
	logic                          map_wdata;
	logic [ffsa_pkg::IDX_W-1:0]    map_raddr;
	logic                          map_rdata_q;

	// Request registers
	ffsa_pkg::mode_t               mode_q;
	logic [ffsa_pkg::SIZE_W-1:0]   size_q;
	logic [ffsa_pkg::START_W-1:0]  first_q;

	// Scan and fill counters
	logic [ffsa_pkg::CNT_W-1:0]    rd_q;
	logic                          pend_q;
	logic [ffsa_pkg::IDX_W-1:0]    chk_q;
	logic [ffsa_pkg::SIZE_W-1:0]   run_q;
	logic [ffsa_pkg::IDX_W-1:0]    wr_q;
	logic [ffsa_pkg::SIZE_W-1:0]   rem_q;
	logic [ffsa_pkg::IDX_W-1:0]    start_q;

	// Response register
	logic                          out_valid_q;
	ffsa_pkg::status_t             out_status_q;
	logic [ffsa_pkg::GRANT_W-1:0]  out_granted_q;

	logic                          rd_end;
	logic                          issue;
	logic [ffsa_pkg::SIZE_W-1:0]   run_next;
	logic                          found;
	logic [ffsa_pkg::CMP_W-1:0]    start_calc;
	logic [ffsa_pkg::CMP_W-1:0]    free_end;
	logic [ffsa_pkg::CMP_W-1:0]    first_ext;
	logic [ffsa_pkg::CMP_W-1:0]    start_ext;
	logic [ffsa_pkg::CMP_W-1:0]    slot_count_ext;

	assign slot_count_ext = ffsa_pkg::CMP_W'(ffsa_pkg::SLOT_COUNT);
	assign first_ext      = ffsa_pkg::CMP_W'(first_q);
	assign start_ext      = ffsa_pkg::CMP_W'(start_q);
	assign free_end       = first_ext + ffsa_pkg::CMP_W'(size_q);

	// Scan: count consecutive free slots as read data returns
	assign rd_end     = (rd_q == ffsa_pkg::CNT_W'(ffsa_pkg::SLOT_COUNT));
	assign issue      = cmd.scan_step && !rd_end;
	assign run_next   = run_q + ffsa_pkg::SIZE_W'(1);
	assign found      = cmd.scan_step && pend_q && !map_rdata_q && (run_next == size_q);
	assign start_calc = ffsa_pkg::CMP_W'(chk_q) + ffsa_pkg::CMP_W'(1)
		- ffsa_pkg::CMP_W'(size_q);

	// Map port selection
	assign map_raddr = rd_q[ffsa_pkg::IDX_W-1:0];
	assign map_we    = cmd.clear_step || cmd.fill_step;
	assign map_waddr = wr_q;
	assign map_wdata = cmd.fill_step && (mode_q == ffsa_pkg::MODE_ALLOC);

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rdata_q <= map_mem[map_raddr];
	end

	// Capture the request on transfer
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q  <= ffsa_pkg::mode_t'(req_mode);
			size_q  <= req_size;
			first_q <= req_start;
		end
	end

	// Advance scan pointer, pending flag and run length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= '0;
			pend_q <= 1'b0;
			run_q  <= '0;
			chk_q  <= '0;
		end else if (cmd.scan_start) begin
			rd_q   <= '0;
			pend_q <= 1'b0;
			run_q  <= '0;
		end else if (cmd.scan_step) begin
			pend_q <= issue;
			if (issue) begin
				rd_q  <= rd_q + ffsa_pkg::CNT_W'(1);
				chk_q <= map_raddr;
			end
			if (pend_q) begin
				run_q <= map_rdata_q ? '0 : run_next;
			end
		end
	end

	// Advance write pointer for the clearing sweep and run fills
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rem_q <= '0;
		end else if (cmd.clear_step || cmd.fill_step) begin
			wr_q  <= wr_q + ffsa_pkg::IDX_W'(1);
			rem_q <= rem_q - ffsa_pkg::SIZE_W'(1);
		end else if (found) begin
			wr_q  <= start_calc[ffsa_pkg::IDX_W-1:0];
			rem_q <= size_q;
		end else if (cmd.free_start) begin
			wr_q  <= first_ext[ffsa_pkg::IDX_W-1:0];
			rem_q <= size_q;
		end
	end

	// Hold the start of the granted run
	always_ff @(posedge clk) begin
		if (found) begin
			start_q <= start_calc[ffsa_pkg::IDX_W-1:0];
		end
	end

	// Response register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q <= cmd.rsp_status;
			if (cmd.rsp_status == ffsa_pkg::ST_OK && mode_q == ffsa_pkg::MODE_ALLOC) begin
				out_granted_q <= start_ext[ffsa_pkg::GRANT_W-1:0];
			end else begin
				out_granted_q <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.granted_slot = out_granted_q;

	// Status toward the controller
	assign stat.mode       = mode_q;
	assign stat.size_zero  = (size_q == '0);
	assign stat.size_big   = (ffsa_pkg::CMP_W'(size_q) > slot_count_ext);
	assign stat.free_oob   = (free_end > slot_count_ext);
	assign stat.found      = found;
	assign stat.scan_done  = rd_end && !pend_q;
	assign stat.fill_last  = (rem_q == ffsa_pkg::SIZE_W'(1));
	assign stat.clear_last = (wr_q == ffsa_pkg::IDX_W'(ffsa_pkg::SLOT_COUNT - 1));
	assign stat.out_free   = !out_valid_q || rsp.ready;

endmodule

@@ hdl/first_fit_slot_allocator.sv @@
// First-fit slot allocator top level: controller and datapath.
//
// Keeps a used/free map of SLOT_COUNT slots (1024) in a one-bit-wide memory with
// one write and one registered read per cycle. After reset the block sweeps the
// map to all free, one slot per cycle, and accepts no request until the sweep
// ends. An allocate scans the map from slot 0 one slot per cycle through the
// read port and then marks the found run one slot per cycle through the write
// port; when no run fits it answers with no space once the scan ends. A zero-size
// or oversize allocate, and a free that runs past the end, answer from the check
// state without touching the map. A free clears its range through the write port.
// The response sits in an output register, so the next request is taken while
// the last response still waits.
module first_fit_slot_allocator (
	input  logic        clk,
	input  logic        arst_n,
	ffsa_req_if.sink    req,
	ffsa_rsp_if.source  rsp
);

	ffsa_pkg::cmd_t  cmd;
	ffsa_pkg::stat_t stat;

	ffsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ffsa_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_mode  (req.mode),
		.req_size  (req.request_size),
		.req_start (req.start_slot),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the first-fit slot allocator: slot map prediction and random traffic.
`timescale 1ns / 100ps

module testbench;

	// Expected response of one request
	typedef struct {
		ffsa_pkg::status_t               status;
		logic [ffsa_pkg::GRANT_W-1:0]    grant;
	} slot_reply_t;

	// Shadow slot map, outstanding replies and the runs currently held
	class slot_map_scoreboard;
		bit          used[ffsa_pkg::SLOT_COUNT];
		slot_reply_t reply_q[$];
		int unsigned held_start[$];
		int unsigned held_size[$];
		int          errors;

		// Predict the reply to an accepted request and update the map
		function void note_request(ffsa_pkg::mode_t op, logic [ffsa_pkg::SIZE_W-1:0] size,
			logic [ffsa_pkg::START_W-1:0] first);
			slot_reply_t reply;
			int unsigned len;
			int unsigned base;
			int unsigned run;
			bit          found;
			len         = 32'(size);
			base        = 32'(first);
			run         = 0;
			found       = 0;
			reply.status = ffsa_pkg::ST_OK;
			reply.grant  = '0;
			if (op == ffsa_pkg::MODE_ALLOC) begin
				// first fit: the run whose last slot is lowest
				if (len != 0 && len <= ffsa_pkg::SLOT_COUNT) begin
					for (int i = 0; i < ffsa_pkg::SLOT_COUNT && !found; i++) begin
						if (!used[i]) begin
							run++;
							if (run == len) begin
								found = 1;
								base  = i + 1 - len;
							end
						end else begin
							run = 0;
						end
					end
				end
				if (found) begin
					for (int i = 0; i < len; i++)
						used[base + i] = 1'b1;
					reply.grant = base[ffsa_pkg::GRANT_W-1:0];
					held_start.push_back(base);
					held_size.push_back(len);
				end else begin
					reply.status = ffsa_pkg::ST_NO_SPACE;
				end
			end else begin
				if (base + len > ffsa_pkg::SLOT_COUNT) begin
					reply.status = ffsa_pkg::ST_OUT_OF_BOUNDS;
				end else begin
					for (int i = 0; i < len; i++)
						used[base + i] = 1'b0;
					// drop every held run that the range touches
					for (int k = held_start.size() - 1; k >= 0; k--) begin
						if (len != 0 && held_start[k] < base + len &&
							base < held_start[k] + held_size[k]) begin
							held_start.delete(k);
							held_size.delete(k);
						end
					end
				end
			end
			reply_q.push_back(reply);
		endfunction

		// Compare one response transfer with the oldest expected reply
		function void check_result(logic [ffsa_pkg::STATUS_W-1:0] got_status,
			logic [ffsa_pkg::GRANT_W-1:0] got_grant);
			slot_reply_t want;
			if (reply_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected response status %0d granted_slot %0d",
					$time, got_status, got_grant);
				return;
			end
			want = reply_q.pop_front();
			if (got_status !== want.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d (%s) actual %0d",
					$time, want.status, want.status.name(), got_status);
			end
			if (got_grant !== want.grant) begin
				errors++;
				$display("%0t: granted_slot mismatch: expected %0d actual %0d",
					$time, want.grant, got_grant);
			end
		endfunction

		function int pending();
			return reply_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ffsa_req_if req ();
	ffsa_rsp_if rsp ();

	first_fit_slot_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	slot_map_scoreboard sb;
	int                 burst_left;
	bit                 hold_off_req;

	// Clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Time limit
	initial begin
		#120ms;
		$display("[first_fit_slot_allocator] ERROR");
		$finish;
	end

	// Check every response transfer
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			sb.check_result(rsp.status, rsp.granted_slot);
	end

	// Receiver: stretches of always ready, random ready and mostly stalled,
	// with one long hold-off on request
	initial begin
		int kind;
		int len;
		rsp.ready = 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp.ready <= 1'b0;
				repeat (2500) @(posedge clk);
			end else begin
				kind = $urandom_range(0, 2);
				len  = $urandom_range(20, 120);
				while (len > 0 && !hold_off_req) begin
					case (kind)
						0: rsp.ready <= 1'b1;
						1: rsp.ready <= 1'($urandom_range(0, 1));
						default: rsp.ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
					len--;
				end
			end
		end
	end

	// Offer one request and hold it until the transfer
	task automatic offer(ffsa_pkg::mode_t op, logic [ffsa_pkg::SIZE_W-1:0] size,
		logic [ffsa_pkg::START_W-1:0] first);
		req.valid        <= 1'b1;
		req.mode         <= op;
		req.request_size <= size;
		req.start_slot   <= first;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, size, first);
	endtask

	// Insert a gap between bursts of random length
	task automatic pace();
		if (burst_left == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8);
		end
		burst_left--;
	endtask

	task automatic issue(ffsa_pkg::mode_t op, logic [ffsa_pkg::SIZE_W-1:0] size,
		logic [ffsa_pkg::START_W-1:0] first);
		pace();
		offer(op, size, first);
	endtask

	// Pick an allocate size, mostly small
	function automatic logic [ffsa_pkg::SIZE_W-1:0] alloc_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return ffsa_pkg::SIZE_W'($urandom_range(1, 8));
		if (r < 88) return ffsa_pkg::SIZE_W'($urandom_range(9, 64));
		if (r < 95) return ffsa_pkg::SIZE_W'($urandom_range(65, 300));
		if (r < 97) return '0;
		if (r < 99) return ffsa_pkg::SIZE_W'($urandom_range(301, 1024));
		return ffsa_pkg::SIZE_W'($urandom_range(1025, 2047));
	endfunction

	// Build one random request: allocations, frees of held runs and noise
	task automatic random_request(output ffsa_pkg::mode_t op,
		output logic [ffsa_pkg::SIZE_W-1:0] size,
		output logic [ffsa_pkg::START_W-1:0] first);
		int r;
		int k;
		int unsigned base;
		int unsigned len;
		r = $urandom_range(0, 99);
		if (sb.held_start.size() == 0 || r < 45) begin
			op    = ffsa_pkg::MODE_ALLOC;
			size  = alloc_size();
			first = ffsa_pkg::START_W'($urandom());
		end else if (r < 87) begin
			// release a held run, now and then only part of it
			k    = $urandom_range(0, sb.held_start.size() - 1);
			base = sb.held_start[k];
			len  = sb.held_size[k];
			if ($urandom_range(0, 9) == 0) begin
				base = base + $urandom_range(0, len - 1);
				len  = $urandom_range(0, sb.held_start[k] + len - base);
			end
			op    = ffsa_pkg::MODE_FREE;
			size  = ffsa_pkg::SIZE_W'(len);
			first = ffsa_pkg::START_W'(base);
		end else if (r < 93) begin
			op    = ffsa_pkg::MODE_FREE;
			size  = ffsa_pkg::SIZE_W'($urandom());
			first = ffsa_pkg::START_W'($urandom());
		end else begin
			op    = ffsa_pkg::MODE_FREE;
			first = ffsa_pkg::START_W'($urandom());
			len   = ffsa_pkg::SLOT_COUNT - 32'(first);
			size  = ffsa_pkg::SIZE_W'($urandom_range(0, (len < 64) ? len : 64));
		end
	endtask

	// Stimulus
	initial begin
		ffsa_pkg::mode_t                op;
		logic [ffsa_pkg::SIZE_W-1:0]    size;
		logic [ffsa_pkg::START_W-1:0]   first;
		sb                = new;
		burst_left        = 0;
		hold_off_req      = 1'b0;
		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.mode          = ffsa_pkg::MODE_ALLOC;
		req.request_size  = '0;
		req.start_slot    = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: size extremes, bounds and first-fit ordering
		issue(ffsa_pkg::MODE_ALLOC, 11'd0, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd1, 10'd1023);
		issue(ffsa_pkg::MODE_ALLOC, 11'd1024, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd2047, 10'd0);
		issue(ffsa_pkg::MODE_FREE, 11'd1024, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd1024, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd1, 10'd0);
		issue(ffsa_pkg::MODE_FREE, 11'd1, 10'd1023);
		issue(ffsa_pkg::MODE_ALLOC, 11'd1, 10'd0);
		issue(ffsa_pkg::MODE_FREE, 11'd2, 10'd1023);
		issue(ffsa_pkg::MODE_FREE, 11'd0, 10'd1023);
		issue(ffsa_pkg::MODE_FREE, 11'd0, 10'd0);
		issue(ffsa_pkg::MODE_FREE, 11'd2047, 10'd0);
		issue(ffsa_pkg::MODE_FREE, 11'd1024, 10'd1023);
		issue(ffsa_pkg::MODE_FREE, 11'd1024, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd3, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd5, 10'd0);
		issue(ffsa_pkg::MODE_FREE, 11'd3, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd2, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd2, 10'd0);
		issue(ffsa_pkg::MODE_ALLOC, 11'd1, 10'd0);
		issue(ffsa_pkg::MODE_FREE, 11'd10, 10'd500);
		issue(ffsa_pkg::MODE_FREE, 11'd1024, 10'd0);
		sb.held_start.delete();
		sb.held_size.delete();

		// Random traffic
		for (int n = 0; n < 560; n++) begin
			if (n == 200) begin
				// stall the receiver and keep the input busy
				hold_off_req = 1'b1;
				for (int j = 0; j < 8; j++) begin
					random_request(op, size, first);
					offer(op, size, first);
				end
			end else if (n == 380) begin
				// drain before going on
				req.valid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
				random_request(op, size, first);
				offer(op, size, first);
			end else begin
				random_request(op, size, first);
				issue(op, size, first);
			end
		end
		req.valid <= 1'b0;

		// Wait for the last replies, then watch for strays
		while (sb.pending() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) begin
			$display("[first_fit_slot_allocator] OK");
		end else begin
			$display("[first_fit_slot_allocator] ERROR");
		end
		$finish;
	end

endmodule
